/* hw/rtl/dlz_pkg.sv */
package dlz_pkg;

  localparam logic [7:0] DESCR_BIAS = 8'h7c;
  localparam logic [7:0] FLAG_FILL  = 8'hff;

  // Token decoder position in the compressed stream.
  typedef enum logic [1:0] {
    PH_FLAG   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_t;

  // Descramble settings derived from the key when it is written.
  typedef struct packed {
    logic [7:0] xor_byte;
    logic [2:0] rot;
  } descr_cfg_t;

  // Low byte of (key >> 24) + (key >> 3).
  function automatic logic [7:0] key_xor_byte(input logic [31:0] key);
    logic [7:0] sum;
    sum = key[31:24] + key[10:3];
    return sum;
  endfunction

  // ((key >> 20) mod 5) + 1. Since 16 mod 5 is 1, add up the nibbles first.
  function automatic logic [2:0] key_rot(input logic [31:0] key);
    logic [5:0] nib_sum;
    logic [4:0] folded;
    logic [4:0] rem;
    nib_sum = {2'b00, key[23:20]} + {2'b00, key[27:24]} + {2'b00, key[31:28]};
    folded  = {3'b000, nib_sum[5:4]} + {1'b0, nib_sum[3:0]};
    if (folded >= 5'd15) begin
      rem = folded - 5'd15;
    end else if (folded >= 5'd10) begin
      rem = folded - 5'd10;
    end else if (folded >= 5'd5) begin
      rem = folded - 5'd5;
    end else begin
      rem = folded;
    end
    return rem[2:0] + 3'd1;
  endfunction

endpackage

/* hw/rtl/dlz_descramble.sv */
module dlz_descramble (
  input  logic [7:0]              raw,
  input  dlz_pkg::descr_cfg_t     cfg,
  output logic [7:0]              plain
);

  logic [7:0]  mixed;
  logic [15:0] doubled;

  // Subtract the bias, mix in the key byte, then rotate right.
  assign mixed   = (raw - dlz_pkg::DESCR_BIAS) ^ cfg.xor_byte;
  assign doubled = {mixed, mixed} >> cfg.rot;
  assign plain   = doubled[7:0];

endmodule

/* hw/rtl/dlz_window.sv */
module dlz_window #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/descramble_lzss_decompressor.sv */
// Descrambling LZSS decompressor. Each request on s_axis is one scrambled
// compressed byte; tlast marks the final byte of a stream. Flag bytes and match
// low bytes give no output. A literal gives one byte on m_axis, and s_axis_tready
// stays low in S_EMIT until that byte is loaded into the output register.
// A match of N bytes (2 to 33) is copied out of the 2048-byte history window
// through its single read port, byte by byte: read in S_READ, then emitted and
// written back in S_EMIT. While m_axis_tready is low the pending byte holds and
// the copy waits. After reset and after every request with tlast the window is
// cleared to zero, one entry a cycle, over all WINDOW_SIZE entries, during which
// s_axis_tready is low. The key on the cfg port is taken at any time and holds
// across streams.
module descramble_lzss_decompressor #(
  parameter int WINDOW_SIZE = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // in_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // run_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data        // scramble_key
);

  localparam int AW = $clog2(WINDOW_SIZE);
  localparam logic [AW-1:0] WPOS_RESET = AW'(WINDOW_SIZE - 33);
  localparam logic [AW-1:0] ADDR_MAX   = AW'(WINDOW_SIZE - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EMIT
  } state_t;

  state_t              state;
  dlz_pkg::phase_t     phase;
  dlz_pkg::phase_t     phase_next;
  dlz_pkg::descr_cfg_t dcfg;
  logic [15:0]         flag_shift;
  logic [15:0]         flag_shift_next;
  logic [7:0]          match_low;
  logic [AW-1:0]       wpos;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       clr_addr;
  logic [5:0]          remain;
  logic                last_item;
  logic                is_literal;
  logic [7:0]          lit_byte;
  logic [7:0]          plain;
  logic                in_take;
  logic                out_free;
  logic                out_load;
  logic [7:0]          out_value;
  logic                out_end;
  logic                win_we;
  logic [AW-1:0]       win_waddr;
  logic [7:0]          win_wdata;
  logic [7:0]          win_rdata;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  dlz_descramble u_descr (
    .raw   (s_axis_tdata),
    .cfg   (dcfg),
    .plain (plain)
  );

  dlz_window #(
    .DEPTH (WINDOW_SIZE),
    .AW    (AW)
  ) u_window (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata (win_wdata),
    .raddr (rd_addr),
    .rdata (win_rdata)
  );

  // A literal goes straight to S_EMIT; a match byte waits in S_READ for the read data.
  assign out_value = is_literal ? lit_byte : win_rdata;
  assign out_end   = is_literal || (remain == '0);
  assign out_load  = (state == S_EMIT) && out_free;

  assign flag_shift_next = flag_shift >> 1;
  assign phase_next      = flag_shift_next[8] ? dlz_pkg::PH_FIRST : dlz_pkg::PH_FLAG;

  always_comb begin
    if (state == S_CLEAR) begin
      win_we    = 1'b1;
      win_waddr = clr_addr;
      win_wdata = '0;
    end else begin
      win_we    = out_load;
      win_waddr = wpos;
      win_wdata = out_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcfg.xor_byte <= '0;
      dcfg.rot      <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      dcfg.xor_byte <= dlz_pkg::key_xor_byte(cfg_data);
      dcfg.rot      <= dlz_pkg::key_rot(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      phase         <= dlz_pkg::PH_FLAG;
      flag_shift    <= '0;
      match_low     <= '0;
      wpos          <= WPOS_RESET;
      clr_addr      <= '0;
      last_item     <= 1'b0;
      is_literal    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= out_value;
        m_axis_tlast  <= out_end;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_MAX) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_take) begin
            last_item <= s_axis_tlast;
            priority if (phase == dlz_pkg::PH_FIRST && flag_shift[0]) begin
              is_literal <= 1'b1;
              lit_byte   <= plain;
              state      <= S_EMIT;
            end else if (phase == dlz_pkg::PH_FIRST) begin
              match_low <= plain;
              phase     <= dlz_pkg::PH_SECOND;
            end else if (phase == dlz_pkg::PH_SECOND) begin
              is_literal <= 1'b0;
              rd_addr    <= {plain[7:5], match_low};
              remain     <= {1'b0, plain[4:0]} + 6'd1;
              state      <= S_READ;
            end else begin
              flag_shift <= {dlz_pkg::FLAG_FILL, plain};
              phase      <= dlz_pkg::PH_FIRST;
            end
            // Items with no output and tlast drop any open token right away.
            if (s_axis_tlast && !(phase == dlz_pkg::PH_FIRST && flag_shift[0])
                && phase != dlz_pkg::PH_SECOND) begin
              state      <= S_CLEAR;
              clr_addr   <= '0;
              phase      <= dlz_pkg::PH_FLAG;
              flag_shift <= '0;
              match_low  <= '0;
              wpos       <= WPOS_RESET;
            end
          end
        end

        S_READ: begin
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (out_load) begin
            wpos    <= wpos + 1'b1;
            rd_addr <= rd_addr + 1'b1;
            if (out_end) begin
              flag_shift <= flag_shift_next;
              phase      <= phase_next;
              state      <= S_IDLE;
              if (last_item) begin
                state      <= S_CLEAR;
                clr_addr   <= '0;
                phase      <= dlz_pkg::PH_FLAG;
                flag_shift <= '0;
                match_low  <= '0;
                wpos       <= WPOS_RESET;
              end
            end else begin
              remain <= remain - 6'd1;
              state  <= S_READ;
            end
          end
        end

        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // Clearing writes zeros into every entry it passes.
  a_clear_writes_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (win_we && win_wdata == 8'h00))
    else $error("window clear does not write zero");

  // A byte loaded for output is offered on the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_axis_tvalid)
    else $error("loaded byte not presented");

  // The final byte of a stream starts the window clear.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_end && last_item) |=> (state == S_CLEAR && wpos == WPOS_RESET))
    else $error("end of stream did not restart the window");
`endif

endmodule

/* tb/sv/dlz_stream_checker.sv */
module dlz_stream_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // in_last
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  input  logic        m_axis_tlast,   // run_last
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [10:0] WPOS_START = 11'h7df;
  localparam int          REPORT_MAX = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  logic [31:0]     key_q;
  logic [7:0]      hist [0:2047];
  logic [10:0]     wr_pos;
  logic [15:0]     flags;
  dlz_pkg::phase_t phase;
  logic [7:0]      low_q;
  out_beat_t       expected_bytes[$];

  function automatic logic [7:0] unscramble(input logic [7:0] raw);
    logic [7:0]  xb;
    int          r;
    logic [7:0]  t;
    logic [15:0] w;
    xb = 8'((key_q >> 24) + (key_q >> 3));
    r  = int'((key_q >> 20) % 5) + 1;
    t  = (raw - dlz_pkg::DESCR_BIAS) ^ xb;
    w  = {t, t} >> r;
    return w[7:0];
  endfunction

  task automatic clear_window();
    for (int i = 0; i < 2048; i++) hist[i] = 8'h00;
    wr_pos = WPOS_START;
    flags  = 16'h0000;
    phase  = dlz_pkg::PH_FLAG;
    low_q  = 8'h00;
  endtask

  task automatic emit_byte(input logic [7:0] v);
    hist[wr_pos] = v;
    wr_pos = wr_pos + 11'd1;
    expected_bytes.push_back('{data: v, last: 1'b0});
  endtask

  task automatic next_token();
    flags = flags >> 1;
    phase = flags[8] ? dlz_pkg::PH_FIRST : dlz_pkg::PH_FLAG;
  endtask

  task automatic decode_byte(input logic [7:0] raw, input logic fin);
    logic [7:0]  b;
    logic [10:0] src;
    int          count;
    int          queued;
    out_beat_t   tail_beat;
    b = unscramble(raw);
    queued = expected_bytes.size();
    case (phase)
      dlz_pkg::PH_FIRST: begin
        if (flags[0]) begin
          emit_byte(b);
          next_token();
        end else begin
          low_q = b;
          phase = dlz_pkg::PH_SECOND;
        end
      end
      dlz_pkg::PH_SECOND: begin
        // copy reads see bytes this same match has just written
        src = {b[7:5], low_q};
        count = int'(b[4:0]) + 2;
        for (int i = 0; i < count; i++) begin
          emit_byte(hist[src]);
          src = src + 11'd1;
        end
        next_token();
      end
      default: begin
        flags = {dlz_pkg::FLAG_FILL, b};
        phase = dlz_pkg::PH_FIRST;
      end
    endcase
    if (expected_bytes.size() > queued) begin
      tail_beat = expected_bytes.pop_back();
      tail_beat.last = 1'b1;
      expected_bytes.push_back(tail_beat);
    end
    if (fin) clear_window();
  endtask

  task automatic compare_result(input logic [7:0] data, input logic last);
    out_beat_t want;
    if (expected_bytes.size() == 0) begin
      if (mismatches < REPORT_MAX)
        $display("%0t: unexpected output byte %02h last %0b", $realtime, data, last);
      mismatches++;
    end else begin
      want = expected_bytes.pop_front();
      if (want.data !== data || want.last !== last) begin
        if (mismatches < REPORT_MAX)
          $display("%0t: output mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                   $realtime, want.data, want.last, data, last);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      key_q = 32'h0;
      clear_window();
      expected_bytes.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) compare_result(m_axis_tdata, m_axis_tlast);
      if (cfg_valid && cfg_ready) key_q = cfg_data;
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tlast);
    end
    pending = expected_bytes.size();
  end

endmodule

/* tb/sv/descramble_lzss_decompressor_tb.sv */
module descramble_lzss_decompressor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 100;
  localparam int          STALL_LIMIT  = 8000;
  localparam int          PHASE_ITEMS  = 20;
  localparam logic [10:0] WPOS_START   = 11'h7df;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  int          mismatches;
  int          pending;
  int          tx_idle_pct;
  int          rx_stall_pct;
  bit          hold_req;
  int          quiet_cycles;
  int          items_sent;
  logic [31:0] key_now;
  logic [7:0]  plain_q[$];
  logic        last_q[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  descramble_lzss_decompressor #(
    .WINDOW_SIZE(2048)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  dlz_stream_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  // receiver: random stalls, plus one long hold-off on request once a byte is offered
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken && m_axis_tvalid) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_stall_pct == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no traffic for %0d cycles, %0d bytes outstanding", STALL_LIMIT, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // inverse of the input descrambling under the current key
  function automatic logic [7:0] scramble(input logic [7:0] d);
    logic [7:0]  xb;
    int          r;
    logic [15:0] w;
    xb = 8'((key_now >> 24) + (key_now >> 3));
    r  = int'((key_now >> 20) % 5) + 1;
    w  = {d, d} << r;
    return (w[15:8] ^ xb) + dlz_pkg::DESCR_BIAS;
  endfunction

  // random key whose rotate amount is sel+1
  function automatic logic [31:0] pick_key(input int sel);
    logic [11:0] hi;
    hi = 12'($urandom_range(818, 0) * 5 + sel);
    return {hi, 20'($urandom)};
  endfunction

  task automatic add(input logic [7:0] d, input logic last);
    plain_q.push_back(d);
    last_q.push_back(last);
  endtask

  task automatic write_key(input logic [31:0] k);
    key_now = k;
    cfg_valid <= 1'b1;
    cfg_data <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_item(input logic [7:0] b, input logic last);
    while (tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_queue();
    logic [7:0] d;
    logic       l;
    while (plain_q.size() > 0) begin
      d = plain_q.pop_front();
      l = last_q.pop_front();
      push_item(scramble(d), l);
      items_sent++;
    end
  endtask

  // drop valid, wait for every expected byte, then let a match in flight finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // one well-formed stream of flag groups, occasionally noise or cut short
  task automatic build_stream();
    int          groups;
    int          len;
    int          cut;
    logic [7:0]  fl;
    logic [10:0] src;
    logic [10:0] pos;
    pos = WPOS_START;
    if ($urandom_range(9, 0) == 0) begin
      repeat ($urandom_range(12, 1)) add(8'($urandom), 1'b0);
    end else begin
      groups = $urandom_range(2, 1);
      repeat (groups) begin
        fl = 8'($urandom);
        add(fl, 1'b0);
        for (int k = 0; k < 8; k++) begin
          if (fl[k]) begin
            add(8'($urandom), 1'b0);
            pos = pos + 11'd1;
          end else begin
            len = ($urandom_range(3, 0) == 0) ? $urandom_range(31, 0) : $urandom_range(6, 0);
            // point near the write position half the time so copies carry data
            src = ($urandom_range(1, 0) == 1) ? pos - 11'($urandom_range(40, 1))
                                               : 11'($urandom);
            add(src[7:0], 1'b0);
            add({src[10:8], 5'(len)}, 1'b0);
            pos = pos + 11'(len + 2);
          end
        end
      end
    end
    if ($urandom_range(3, 0) == 0 && plain_q.size() > 1) begin
      cut = $urandom_range(plain_q.size() - 1, 1);
      while (plain_q.size() > cut) begin
        void'(plain_q.pop_back());
        void'(last_q.pop_back());
      end
    end
    void'(last_q.pop_back());
    last_q.push_back(1'b1);
  endtask

  task automatic run_phase(input int budget);
    int start;
    start = items_sent;
    while (items_sent - start < budget) begin
      build_stream();
      send_queue();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    s_axis_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 32'h0;
    hold_req = 1'b0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    items_sent = 0;
    key_now = 32'h0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_key(32'h0000_0000);
    // literals at both extremes, short match, long match overlapping the write
    // position, match wrapping past the top of the window
    add(8'b1100_1011, 1'b0);
    add(8'h00, 1'b0);
    add(8'hff, 1'b0);
    add(8'hdf, 1'b0);
    add(8'he0, 1'b0);
    add(8'ha5, 1'b0);
    add(8'he1, 1'b0);
    add(8'hff, 1'b0);
    add(8'hff, 1'b0);
    add(8'he1, 1'b0);
    add(8'h3c, 1'b0);
    add(8'h81, 1'b1);
    // stream ending inside a match: token is dropped
    add(8'h00, 1'b0);
    add(8'h12, 1'b1);
    // stream ending on a flag byte
    add(8'h5a, 1'b1);
    // stream ending on a match high byte, offset zero
    add(8'hfe, 1'b0);
    add(8'h00, 1'b0);
    add(8'h00, 1'b1);
    // run of one repeated byte, then longest match from the bottom of the window
    add(8'h01, 1'b0);
    add(8'h7f, 1'b0);
    add(8'hdf, 1'b0);
    add(8'he5, 1'b0);
    add(8'h00, 1'b0);
    add(8'h1f, 1'b1);
    send_queue();
    settle();

    write_key(32'hffff_ffff);
    run_phase(PHASE_ITEMS);
    settle();

    tx_idle_pct = 83;
    write_key(pick_key(1));
    run_phase(PHASE_ITEMS);
    settle();

    tx_idle_pct = 0;
    rx_stall_pct = 83;
    write_key(pick_key(2));
    run_phase(PHASE_ITEMS);
    settle();

    tx_idle_pct = 34;
    rx_stall_pct = 34;
    write_key(pick_key(3));
    run_phase(PHASE_ITEMS);
    settle();

    // long receiver hold-off while the sender keeps offering
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    write_key(pick_key(4));
    hold_req = 1'b1;
    run_phase(PHASE_ITEMS);
    settle();

    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (pending != 0) $display("%0d expected bytes never arrived", pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/dlz_pkg.sv
hw/rtl/dlz_descramble.sv
hw/rtl/dlz_window.sv
hw/rtl/descramble_lzss_decompressor.sv
tb/sv/dlz_stream_checker.sv
tb/sv/descramble_lzss_decompressor_tb.sv
